// ===== hw/rtl/key_matrix_debounce_note_mapper_assert.svh =====
// Assertion macros for the key matrix debounce and note mapper.
`ifndef KEY_MATRIX_DEBOUNCE_NOTE_MAPPER_ASSERT_SVH
`define KEY_MATRIX_DEBOUNCE_NOTE_MAPPER_ASSERT_SVH

`ifndef SYNTHESIS

// Clocked check that is switched off while reset is applied.
`define KMDNM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked check that also holds while reset is applied.
`define KMDNM_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define KMDNM_ASSERT(lbl, prop, msg)
`define KMDNM_ASSERT_RST(lbl, prop, msg)

`endif

`endif

// ===== hw/rtl/kmdnm_pkg.sv =====
// Package with the item types, register indexes and constants of the note mapper.
`timescale 1ns / 1ps

package kmdnm_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MIDI_CHANNEL  = 3'd0,
		CFG_ROOT_NOTE     = 3'd1,
		CFG_TRANSPOSE     = 3'd2,
		CFG_OCTAVE_SHIFT  = 3'd3,
		CFG_LAYER_OFFSET  = 3'd4,
		CFG_DEBOUNCE_TIME = 3'd5
	} cfg_reg_e;

	localparam logic [3:0] STATUS_NOTE_ON  = 4'h9;
	localparam logic [3:0] STATUS_NOTE_OFF = 4'h8;

	localparam logic [6:0] ROOT_NOTE_RESET = 7'd36;
	localparam logic [7:0] DEBOUNCE_RESET  = 8'd8;

	localparam int VEL_SCALE = 107;
	localparam int VEL_DIV   = 1023;
	localparam int VEL_BASE  = 20;
	localparam int NOTE_MAX  = 127;

	typedef struct packed {
		logic [2:0]  key_row;
		logic [2:0]  key_col;
		logic        key_down;
		logic [31:0] now_ms;
		logic [9:0]  velocity_adc;
	} key_sample_t;

	typedef struct packed {
		logic [7:0] status_byte;
		logic [6:0] note_number;
		logic [6:0] note_velocity;
	} midi_msg_t;

endpackage

// ===== hw/rtl/key_matrix_debounce_note_mapper.sv =====
// Key matrix debounce and MIDI note-on/note-off mapper, top level.
//
// Usage: key samples enter on the key channel (key_valid, key_stall, key_sample).
// Each item is one raw sample of one key with its millisecond time stamp and
// velocity reading. A sample that differs from the debounced state of its key,
// arriving strictly more than the debounce time after that key's last change,
// flips the state and yields one MIDI item on the midi channel (midi_valid,
// midi_stall, midi_msg). Any other sample yields nothing.
// Pipeline: the per-key memory is read at the edge that accepts an item, and the
// decision and note mapping then load the output register, from which the
// receiver takes the item. One item is taken every cycle while the key channel
// does not stall.
// The key channel stalls only when an item that produces a message finds the
// output register full and the receiver stalling it; items that produce no
// message pass through regardless.
// Reset releases all keys, clears every last-change time to zero through a
// per-key written flag, and loads the register defaults; no clearing pass is
// needed. Configuration is written through cfg_wr_en, cfg_index and cfg_data
// while the block is idle.
`timescale 1ns / 1ps

module key_matrix_debounce_note_mapper #(
	parameter int KEY_COUNT = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [kmdnm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [kmdnm_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                                key_valid,
	output logic                                key_stall,
	input  kmdnm_pkg::key_sample_t              key_sample,
	output logic                                midi_valid,
	input  logic                                midi_stall,
	output kmdnm_pkg::midi_msg_t                midi_msg
);
	import kmdnm_pkg::*;

	localparam int         KW        = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
	localparam logic [8:0] KEY_LIMIT = 9'(KEY_COUNT);

	// Configuration registers
	logic [3:0]        midi_channel_q;
	logic [6:0]        root_note_q;
	logic signed [5:0] transpose_q;
	logic signed [2:0] octave_q;
	logic [6:0]        layer_offset_q;
	logic [7:0]        debounce_q;

	// Per-key state: each memory word holds the debounced flag above the last-change time.
	logic [KEY_COUNT-1:0] written_q;
	logic [32:0]          key_mem [KEY_COUNT];

	// Stage one and output stage
	logic        valid_s1;
	key_sample_t sample_s1;
	logic [32:0] mem_rd_s1;
	logic        byp_hit_s1;
	logic [32:0] byp_word_s1;
	logic        note_valid_s2;
	midi_msg_t   note_s2;

	logic [5:0]    key_in;
	logic [KW-1:0] addr_in;
	logic [5:0]    key_s1;
	logic [KW-1:0] addr_s1;
	logic          in_range_s1;
	logic [32:0]   last_word;
	logic [31:0]   last_time;
	logic          last_down;
	logic [31:0]   elapsed;
	logic          changed;
	logic          gap_ok;
	logic          emit;
	logic          out_free;
	logic          adv;
	logic          accept;
	logic          commit;

	logic [16:0]        vel_prod;
	logic [6:0]         vel_q0;
	logic [16:0]        vel_rem;
	logic [6:0]         vel_quot;
	logic signed [9:0]  oct_ext;
	logic signed [9:0]  note_sum;
	logic [6:0]         note_clamped;
	midi_msg_t          result;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			midi_channel_q <= '0;
			root_note_q    <= ROOT_NOTE_RESET;
			transpose_q    <= '0;
			octave_q       <= '0;
			layer_offset_q <= '0;
			debounce_q     <= DEBOUNCE_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_MIDI_CHANNEL:  midi_channel_q <= cfg_data[3:0];
				CFG_ROOT_NOTE:     root_note_q    <= cfg_data[6:0];
				CFG_TRANSPOSE:     transpose_q    <= signed'(cfg_data[5:0]);
				CFG_OCTAVE_SHIFT:  octave_q       <= signed'(cfg_data[2:0]);
				CFG_LAYER_OFFSET:  layer_offset_q <= cfg_data[6:0];
				CFG_DEBOUNCE_TIME: debounce_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	assign key_in  = {key_sample.key_row, key_sample.key_col};
	assign addr_in = KW'(key_in);
	assign key_s1  = {sample_s1.key_row, sample_s1.key_col};
	assign addr_s1 = KW'(key_s1);
	assign in_range_s1 = {3'b000, key_s1} < KEY_LIMIT;

	// An entry written at the edge that loaded stage one is not yet in the read data.
	always_comb begin
		if (byp_hit_s1) begin
			last_word = byp_word_s1;
		end else if (written_q[addr_s1]) begin
			last_word = mem_rd_s1;
		end else begin
			last_word = '0;
		end
	end

	assign last_time = last_word[31:0];
	assign last_down = last_word[32];
	assign elapsed = sample_s1.now_ms - last_time;
	assign changed = sample_s1.key_down != last_down;
	assign gap_ok  = elapsed > 32'(debounce_q);
	assign emit    = valid_s1 && in_range_s1 && changed && gap_ok;

	assign out_free  = !note_valid_s2 || !midi_stall;
	assign adv       = valid_s1 && (!emit || out_free);
	assign key_stall = valid_s1 && !adv;
	assign accept    = key_valid && !key_stall;
	assign commit    = adv && emit;

	// Velocity: the quotient by 1023 is the top bits or one more, fixed by one compare.
	always_comb begin
		vel_prod = 17'(sample_s1.velocity_adc) * 17'(VEL_SCALE);
		vel_q0   = vel_prod[16:10];
		vel_rem  = vel_prod - ((17'(vel_q0) << 10) - 17'(vel_q0));
		vel_quot = vel_q0 + 7'(vel_rem >= 17'(VEL_DIV));
	end

	always_comb begin
		oct_ext  = 10'(octave_q);
		note_sum = signed'(10'(root_note_q)) + signed'(10'(key_s1))
			+ 10'(transpose_q) + (oct_ext <<< 3) + (oct_ext <<< 2)
			+ signed'(10'(layer_offset_q));
		if (note_sum < 10'sd0) begin
			note_clamped = '0;
		end else if (note_sum > 10'(NOTE_MAX)) begin
			note_clamped = 7'(NOTE_MAX);
		end else begin
			note_clamped = note_sum[6:0];
		end
	end

	always_comb begin
		result.note_number = note_clamped;
		if (sample_s1.key_down) begin
			result.status_byte   = {STATUS_NOTE_ON, midi_channel_q};
			result.note_velocity = vel_quot + 7'(VEL_BASE);
		end else begin
			result.status_byte   = {STATUS_NOTE_OFF, midi_channel_q};
			result.note_velocity = '0;
		end
	end

	// Per-key memory
	always_ff @(posedge clk) begin
		if (commit) begin
			key_mem[addr_s1] <= {sample_s1.key_down, sample_s1.now_ms};
		end
		if (accept) begin
			mem_rd_s1 <= key_mem[addr_in];
		end
	end

	// Stage one control and per-key written flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			byp_hit_s1 <= 1'b0;
			written_q  <= '0;
		end else begin
			if (accept) begin
				valid_s1   <= 1'b1;
				byp_hit_s1 <= commit && (key_s1 == key_in);
			end else if (adv) begin
				valid_s1   <= 1'b0;
				byp_hit_s1 <= 1'b0;
			end
			if (commit) begin
				written_q[addr_s1] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1   <= key_sample;
			byp_word_s1 <= {sample_s1.key_down, sample_s1.now_ms};
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			note_valid_s2 <= 1'b0;
		end else if (out_free) begin
			note_valid_s2 <= commit;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			note_s2 <= result;
		end
	end

	assign midi_valid = note_valid_s2;
	assign midi_msg   = note_s2;

`include "key_matrix_debounce_note_mapper_assert.svh"

	`KMDNM_ASSERT(a_off_has_zero_velocity, midi_valid |-> (midi_msg.status_byte[4] == (midi_msg.note_velocity != 7'd0)), "note-off must carry zero velocity and note-on a nonzero one")
	`KMDNM_ASSERT(a_status_high_nibble, midi_valid |-> (midi_msg.status_byte[7:5] == 3'b100), "status byte is neither note-on nor note-off")
	`KMDNM_ASSERT(a_stall_only_on_full_output, key_stall |-> (valid_s1 && note_valid_s2 && midi_stall && emit), "key channel stalled without a blocked message")
	`KMDNM_ASSERT(a_commit_records_key, commit |=> (note_valid_s2 && written_q[$past(addr_s1)]), "accepted change was not recorded")
	`KMDNM_ASSERT_RST(a_idle_never_stalls, !valid_s1 |-> !key_stall, "key channel stalled while stage one is empty")

endmodule
